[rtl/brl_pkg.sv]
// Shared constants and item types for the Bresenham line rasterizer.
package brl_pkg;

    localparam int COORD_WIDTH = 14;
    localparam int ERR_WIDTH   = COORD_WIDTH + 2;
    localparam int COLOUR_WIDTH = 8;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef logic [COORD_WIDTH-1:0]  coord_t;
    typedef logic [COLOUR_WIDTH-1:0] colour_t;
    typedef logic signed [ERR_WIDTH-1:0] err_t;

    typedef struct packed {
        logic    cmd;
        coord_t  start_x;
        coord_t  start_y;
        coord_t  end_x;
        coord_t  end_y;
        colour_t line_red;
        colour_t line_green;
        colour_t line_blue;
    } brl_in_t;

    typedef struct packed {
        logic    pixel_valid;
        coord_t  pixel_x;
        coord_t  pixel_y;
        colour_t pixel_red;
        colour_t pixel_green;
        colour_t pixel_blue;
        logic    pixel_last;
    } brl_out_t;

endpackage

[rtl/bresenham_line_rasterizer.sv]
// Bresenham line rasterizer: all-octant integer line walk, one pixel per item.
//
// A start item (cmd = 0) loads both endpoints and the line colour and returns the
// first endpoint as a pixel; each advance item (cmd = 1) takes one step of the
// Bresenham walk and returns the pixel reached, with pixel_last set on the second
// endpoint, after which the line goes inactive. An advance with no active line
// returns an item with pixel_valid and every other field at zero. A start while a
// line is running abandons it. The block takes one item per clock unless stalled:
// the step logic (a doubled-error compare and one add/subtract per axis) sits between
// the walk state registers and a single output register, and the result is presented
// the cycle after the item is accepted. req_ready is low only while a result waits in
// the output register and rsp_ready is low, so throughput is set by the consumer.
module bresenham_line_rasterizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  brl_pkg::brl_in_t   req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output brl_pkg::brl_out_t  rsp
);
    import brl_pkg::*;

    // Walk state
    logic    line_active_reg, line_active_next;
    coord_t  current_x_reg, current_x_next;
    coord_t  current_y_reg, current_y_next;
    coord_t  target_x_reg, target_x_next;
    coord_t  target_y_reg, target_y_next;
    coord_t  span_x_reg, span_x_next;
    coord_t  span_y_reg, span_y_next;
    logic    step_x_neg_reg, step_x_neg_next;
    logic    step_y_neg_reg, step_y_neg_next;
    err_t    error_reg, error_next;
    colour_t red_reg, red_next;
    colour_t green_reg, green_next;
    colour_t blue_reg, blue_next;

    // Output register
    logic     rsp_valid_reg;
    brl_out_t rsp_reg, rsp_next;

    logic accept;

    // Step decision, one bit wider than the error term
    logic signed [ERR_WIDTH:0] doubled;
    logic signed [ERR_WIDTH:0] span_x_wide;
    logic signed [ERR_WIDTH:0] span_y_wide;
    logic step_x, step_y;
    err_t span_x_err, span_y_err;
    coord_t step_cx, step_cy;
    logic   start_last;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign doubled     = {error_reg, 1'b0};
    assign span_x_wide = $signed({{(ERR_WIDTH + 1 - COORD_WIDTH){1'b0}}, span_x_reg});
    assign span_y_wide = $signed({{(ERR_WIDTH + 1 - COORD_WIDTH){1'b0}}, span_y_reg});
    assign span_x_err  = $signed({{(ERR_WIDTH - COORD_WIDTH){1'b0}}, span_x_reg});
    assign span_y_err  = $signed({{(ERR_WIDTH - COORD_WIDTH){1'b0}}, span_y_reg});

    assign step_x = doubled > -span_y_wide;
    assign step_y = doubled < span_x_wide;

    always_comb
    begin
        line_active_next = line_active_reg;
        current_x_next   = current_x_reg;
        current_y_next   = current_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        span_x_next      = span_x_reg;
        span_y_next      = span_y_reg;
        step_x_neg_next  = step_x_neg_reg;
        step_y_neg_next  = step_y_neg_reg;
        error_next       = error_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        rsp_next         = '0;
        step_cx          = current_x_reg;
        step_cy          = current_y_reg;
        start_last       = (req.start_x == req.end_x) && (req.start_y == req.end_y);

        if (req.cmd == CMD_START)
        begin
            // Load a new line and emit its first endpoint
            current_x_next  = req.start_x;
            current_y_next  = req.start_y;
            target_x_next   = req.end_x;
            target_y_next   = req.end_y;
            span_x_next     = (req.end_x > req.start_x) ? req.end_x - req.start_x
                                                        : req.start_x - req.end_x;
            span_y_next     = (req.end_y > req.start_y) ? req.end_y - req.start_y
                                                        : req.start_y - req.end_y;
            step_x_neg_next = !(req.start_x < req.end_x);
            step_y_neg_next = !(req.start_y < req.end_y);
            error_next      = $signed({{(ERR_WIDTH - COORD_WIDTH){1'b0}}, span_x_next})
                            - $signed({{(ERR_WIDTH - COORD_WIDTH){1'b0}}, span_y_next});
            red_next        = req.line_red;
            green_next      = req.line_green;
            blue_next       = req.line_blue;
            line_active_next = !start_last;

            rsp_next.pixel_valid = 1'b1;
            rsp_next.pixel_x     = req.start_x;
            rsp_next.pixel_y     = req.start_y;
            rsp_next.pixel_red   = req.line_red;
            rsp_next.pixel_green = req.line_green;
            rsp_next.pixel_blue  = req.line_blue;
            rsp_next.pixel_last  = start_last;
        end
        else if (line_active_reg)
        begin
            // One Bresenham step; both axes may move together
            if (step_x)
            begin
                step_cx = step_x_neg_reg ? current_x_reg - 1'b1 : current_x_reg + 1'b1;
            end
            if (step_y)
            begin
                step_cy = step_y_neg_reg ? current_y_reg - 1'b1 : current_y_reg + 1'b1;
            end
            error_next = error_reg - (step_x ? span_y_err : '0) + (step_y ? span_x_err : '0);
            current_x_next = step_cx;
            current_y_next = step_cy;
            rsp_next.pixel_last = (step_cx == target_x_reg) && (step_cy == target_y_reg);
            line_active_next    = !rsp_next.pixel_last;

            rsp_next.pixel_valid = 1'b1;
            rsp_next.pixel_x     = step_cx;
            rsp_next.pixel_y     = step_cy;
            rsp_next.pixel_red   = red_reg;
            rsp_next.pixel_green = green_reg;
            rsp_next.pixel_blue  = blue_reg;
        end
        // else: advance with no line, all-zero result, state untouched
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            current_x_reg   <= '0;
            current_y_reg   <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            span_x_reg      <= '0;
            span_y_reg      <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            error_reg       <= '0;
            red_reg         <= '0;
            green_reg       <= '0;
            blue_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                line_active_reg <= line_active_next;
                current_x_reg   <= current_x_next;
                current_y_reg   <= current_y_next;
                target_x_reg    <= target_x_next;
                target_y_reg    <= target_y_next;
                span_x_reg      <= span_x_next;
                span_y_reg      <= span_y_next;
                step_x_neg_reg  <= step_x_neg_next;
                step_y_neg_reg  <= step_y_neg_next;
                error_reg       <= error_next;
                red_reg         <= red_next;
                green_reg       <= green_next;
                blue_reg        <= blue_next;
                rsp_valid_reg   <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

[bench/tb_bresenham_line_rasterizer.sv]
// Self-checking testbench for the Bresenham line rasterizer: directed and random lines.
module tb_bresenham_line_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;

    import brl_pkg::*;

    localparam int COORD_MAX   = (1 << COORD_WIDTH) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1900;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    brl_in_t  req;
    logic     rsp_valid;
    logic     rsp_ready;
    brl_out_t rsp;

    // Pixels still owed by the block, oldest first.
    brl_out_t pixel_queue[$];

    // Walk state of the predictor; kept in plain ints so the error term
    // behaves as a signed value with headroom.
    bit      walk_active;
    int      walk_x;
    int      walk_y;
    int      goal_x;
    int      goal_y;
    int      dist_x;
    int      dist_y;
    bit      back_x;
    bit      back_y;
    int      walk_err;
    colour_t walk_red;
    colour_t walk_green;
    colour_t walk_blue;

    int mismatches;
    int sent_items;
    bit idle_on;       // random idling on both sides
    int hold_cycles;   // long stall request for the receiver

    bresenham_line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop should the block hang.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Works out the pixel that one accepted item must produce, and moves the walk on.
    function automatic brl_out_t next_pixel(input brl_in_t it);
        brl_out_t px;
        int       twice;
        bit       at_end;
        px = '0;
        if (it.cmd == CMD_START)
        begin
            walk_x     = it.start_x;
            walk_y     = it.start_y;
            goal_x     = it.end_x;
            goal_y     = it.end_y;
            dist_x     = (goal_x > walk_x) ? goal_x - walk_x : walk_x - goal_x;
            dist_y     = (goal_y > walk_y) ? goal_y - walk_y : walk_y - goal_y;
            back_x     = !(walk_x < goal_x);
            back_y     = !(walk_y < goal_y);
            walk_err   = dist_x - dist_y;
            walk_red   = it.line_red;
            walk_green = it.line_green;
            walk_blue  = it.line_blue;
            at_end      = (walk_x == goal_x) && (walk_y == goal_y);
            walk_active = !at_end;
        end
        else if (!walk_active)
        begin
            // advance with nothing to draw: all-zero item, state untouched
            return px;
        end
        else
        begin
            twice = walk_err * 2;
            if (twice > -dist_y)
            begin
                walk_err -= dist_y;
                walk_x   += back_x ? -1 : 1;
            end
            if (twice < dist_x)
            begin
                walk_err += dist_x;
                walk_y   += back_y ? -1 : 1;
            end
            at_end = (walk_x == goal_x) && (walk_y == goal_y);
            if (at_end)
                walk_active = 1'b0;
        end
        px.pixel_valid = 1'b1;
        px.pixel_x     = coord_t'(walk_x);
        px.pixel_y     = coord_t'(walk_y);
        px.pixel_red   = walk_red;
        px.pixel_green = walk_green;
        px.pixel_blue  = walk_blue;
        px.pixel_last  = at_end;
        return px;
    endfunction

    function automatic void compare_field(input string what, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // Scoreboard: pre-edge values are sampled, since all drives land as NBAs.
    // A result can never belong to the item taken at the same edge (the result is
    // registered), so checking before predicting is safe.
    always @(posedge clk)
    begin
        brl_out_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected item, expected none, got %p", $time, rsp);
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    compare_field("pixel_valid", want.pixel_valid, rsp.pixel_valid);
                    compare_field("pixel_x",     want.pixel_x,     rsp.pixel_x);
                    compare_field("pixel_y",     want.pixel_y,     rsp.pixel_y);
                    compare_field("pixel_red",   want.pixel_red,   rsp.pixel_red);
                    compare_field("pixel_green", want.pixel_green, rsp.pixel_green);
                    compare_field("pixel_blue",  want.pixel_blue,  rsp.pixel_blue);
                    compare_field("pixel_last",  want.pixel_last,  rsp.pixel_last);
                end
            end
            if (req_valid && req_ready)
                pixel_queue.push_back(next_pixel(req));
        end
    end

    // Receiver: random stall bursts while idling is on, plus one long hold-off
    // on request, counted here so the sender keeps pushing meanwhile.
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    // Offers one item and returns at the edge where it is taken. Valid stays
    // high into the next item unless an idle burst is drawn.
    task automatic send_item(input brl_in_t it);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        sent_items++;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    function automatic brl_in_t random_item(input logic op);
        brl_in_t it;
        it         = brl_in_t'({$urandom, $urandom, $urandom});
        it.cmd     = op;
        return it;
    endfunction

    task automatic start_line(input int x0, input int y0, input int x1, input int y1,
                              input logic [23:0] rgb);
        brl_in_t it;
        it            = random_item(CMD_START);
        it.start_x    = coord_t'(x0);
        it.start_y    = coord_t'(y0);
        it.end_x      = coord_t'(x1);
        it.end_y      = coord_t'(y1);
        {it.line_red, it.line_green, it.line_blue} = rgb;
        send_item(it);
    endtask

    task automatic advance(input int count);
        repeat (count) send_item(random_item(CMD_ADVANCE));
    endtask

    // Holds the sender until every owed pixel has come back. An edge passes
    // first so the item taken at the last edge is already in the queue.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pixel_queue.size() != 0)
            @(posedge clk);
    endtask

    // One line with a random start, an end within reach (or anywhere for a
    // full-span line, which is then cut short), and a walk that is mostly
    // finished, sometimes abandoned and sometimes overrun into idle advances.
    task automatic draw_random_line(input int reach, input bit full_span);
        brl_in_t it;
        int      x1;
        int      y1;
        int      span;
        int      steps;
        it = random_item(CMD_START);
        if (!full_span)
        begin
            x1 = int'(it.start_x) + $urandom_range(0, 2 * reach) - reach;
            y1 = int'(it.start_y) + $urandom_range(0, 2 * reach) - reach;
            x1 = (x1 < 0) ? 0 : (x1 > COORD_MAX) ? COORD_MAX : x1;
            y1 = (y1 < 0) ? 0 : (y1 > COORD_MAX) ? COORD_MAX : y1;
            it.end_x = coord_t'(x1);
            it.end_y = coord_t'(y1);
        end
        x1   = int'(it.end_x) - int'(it.start_x);
        y1   = int'(it.end_y) - int'(it.start_y);
        x1   = (x1 < 0) ? -x1 : x1;
        y1   = (y1 < 0) ? -y1 : y1;
        span = (x1 > y1) ? x1 : y1;
        if (full_span)
            steps = $urandom_range(0, 6);
        else
            case ($urandom_range(0, 9))
                0:       steps = $urandom_range(0, span);
                1:       steps = span + $urandom_range(1, 2);
                default: steps = span;
            endcase
        send_item(it);
        advance(steps);
    endtask

    // ---------------------------------------------------------------- tests

    // Advance straight after reset, and again after a line has ended.
    task automatic test_idle_advance();
        advance(2);
        start_line(7, 9, 8, 9, 24'h123456);
        advance(2);
    endtask

    // Both endpoints equal: the start item alone closes the line.
    task automatic test_single_point();
        start_line(0, 0, 0, 0, 24'h000000);
        start_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'hFFFFFF);
        advance(1);
    endtask

    // Shallow forward, steep with x going back, and a diagonal walking down
    // from the top corner.
    task automatic test_octants();
        start_line(0, 0, 2, 1, 24'hFF0000);
        advance(2);
        start_line(5, 5, 4, 8, 24'h00FF00);
        advance(3);
        start_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 2, 24'h0000FF);
        advance(2);
    endtask

    // A full-diagonal line is dropped by a new start partway through.
    task automatic test_restart();
        start_line(0, COORD_MAX, COORD_MAX, 0, 24'hA5A55A);
        advance(2);
        start_line(3, 3, 3, 5, 24'h5A5AA5);
        advance(2);
    endtask

    task automatic test_random_lines();
        while (sent_items < ITEM_TARGET - 200)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 29) == 0)
                advance(1);
            else
                draw_random_line($urandom_range(0, 1) ? 4 : 24, $urandom_range(0, 24) == 0);
        end
    endtask

    // Receiver holds off for a long stretch while a line keeps coming in.
    task automatic test_backpressure();
        idle_on     = 1'b0;
        hold_cycles = 60;
        start_line(100, 200, 130, 215, 24'h808080);
        advance(30);
    endtask

    // Sender stops until every pixel is back, then carries on.
    task automatic test_drain_pause();
        idle_on = 1'b1;
        draw_random_line(12, 1'b0);
        wait_for_drain();
        draw_random_line(12, 1'b0);
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_quiet_tail();
        idle_on = 1'b0;
        while (sent_items < ITEM_TARGET)
            draw_random_line(8, 1'b0);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        idle_on     = 1'b0;
        hold_cycles = 0;
        mismatches  = 0;
        sent_items  = 0;
        walk_active = 1'b0;
        walk_x      = 0;
        walk_y      = 0;
        goal_x      = 0;
        goal_y      = 0;
        dist_x      = 0;
        dist_y      = 0;
        back_x      = 1'b0;
        back_y      = 1'b0;
        walk_err    = 0;
        walk_red    = '0;
        walk_green  = '0;
        walk_blue   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_advance();
        test_single_point();
        test_octants();
        test_restart();
        test_random_lines();
        test_backpressure();
        test_drain_pause();
        test_quiet_tail();

        // Let the last pixels arrive, then wait on for strays.
        wait_for_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
